// ----- rtl/core/cell_grid_neighbor_counter_top_assert.svh -----
`ifndef CELL_GRID_NEIGHBOR_COUNTER_TOP_ASSERT_SVH
`define CELL_GRID_NEIGHBOR_COUNTER_TOP_ASSERT_SVH

// same-cycle implication
`define CGNC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CGNC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/cgnc_pkg.sv -----
package cgnc_pkg;

  localparam int GRID_COLS_MAX = 64;
  localparam int GRID_ROWS_MAX = 64;
  localparam int CELL_BITS     = 8;

  localparam int STORE_DEPTH = GRID_COLS_MAX * GRID_ROWS_MAX;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int AREA_W      = ADDR_W + 1;

  localparam int OP_W    = 2;
  localparam int COORD_W = 6;
  localparam int SIZE_W  = COORD_W + 1;
  localparam int STATE_W = 8;
  localparam int COUNT_W = 4;
  localparam int NB_W    = 3;
  localparam int STEP_W  = $clog2(COORD_W);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam int IN_FIELDS_W  = 2 * COORD_W + STATE_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STATE_W + COUNT_W + 1;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int X_LSB     = 0;
  localparam int Y_LSB     = COORD_W;
  localparam int ST_LSB    = 2 * COORD_W;
  localparam int VALUE_LSB = 0;
  localparam int COUNT_LSB = STATE_W;
  localparam int DONE_BIT  = STATE_W + COUNT_W;

  localparam logic [SIZE_W-1:0]  COLS_MAX_S  = SIZE_W'(GRID_COLS_MAX);
  localparam logic [SIZE_W-1:0]  ROWS_MAX_S  = SIZE_W'(GRID_ROWS_MAX);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(8);
  localparam logic [NB_W-1:0]    NB_MOORE_LAST = NB_W'(7);
  localparam logic [NB_W-1:0]    NB_VN_LAST    = NB_W'(3);

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_MOORE = 2'd2;
  localparam logic [OP_W-1:0] OP_VN    = 2'd3;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = SIZE_W;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WRAP   = 2'd2;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_READ,
    KIND_MOORE,
    KIND_VN
  } kind_e;

  typedef enum logic [1:0] {
    OFF_M1,
    OFF_Z,
    OFF_P1
  } off_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    kind_e               kind;
    logic [COORD_W-1:0]  x_coord;
    logic [COORD_W-1:0]  y_coord;
    logic [STATE_W-1:0]  key_state;
  } item_t;

  typedef struct packed {
    logic               wrap;
    logic [SIZE_W-1:0]  w;
    logic [SIZE_W-1:0]  h;
  } cfg_t;

  typedef struct packed {
    logic                write_done;
    logic [COUNT_W-1:0]  neighbor_count;
    logic [STATE_W-1:0]  cell_value;
  } result_t;

  typedef struct packed {
    logic               off;
    logic [COORD_W-1:0] c;
  } coord_t;

  function automatic logic [SIZE_W-1:0] eff_size(logic [SIZE_W-1:0] raw,
                                                 logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    r = raw;
    if (raw == '0) r = SIZE_W'(1);
    else if (raw > maxv) r = maxv;
    return r;
  endfunction

  // VN neighbors first, diagonals after
  function automatic off_e nb_dx(logic [NB_W-1:0] nb);
    off_e r;
    case (nb)
      3'd1, 3'd4, 3'd6: r = OFF_M1;
      3'd2, 3'd5, 3'd7: r = OFF_P1;
      default:          r = OFF_Z;
    endcase
    return r;
  endfunction

  function automatic off_e nb_dy(logic [NB_W-1:0] nb);
    off_e r;
    case (nb)
      3'd0, 3'd4, 3'd5: r = OFF_M1;
      3'd3, 3'd6, 3'd7: r = OFF_P1;
      default:          r = OFF_Z;
    endcase
    return r;
  endfunction

  function automatic coord_t next_coord(logic [COORD_W-1:0] raw,
                                        logic [COORD_W-1:0] red,
                                        logic [SIZE_W-1:0]  size,
                                        logic               wrap,
                                        off_e               off);
    coord_t r;
    logic [SIZE_W-1:0] c;
    r.off = 1'b0;
    c = '0;
    if (wrap) begin
      case (off)
        OFF_M1:  c = (red == '0) ? size - 1'b1 : SIZE_W'(red) - 1'b1;
        OFF_P1:  c = (SIZE_W'(red) + 1'b1 == size) ? '0 : SIZE_W'(red) + 1'b1;
        default: c = SIZE_W'(red);
      endcase
    end else begin
      case (off)
        OFF_M1: begin
          r.off = (raw == '0);
          c = SIZE_W'(raw) - 1'b1;
        end
        OFF_P1:  c = SIZE_W'(raw) + 1'b1;
        default: c = SIZE_W'(raw);
      endcase
      if (c >= size) r.off = 1'b1;
    end
    r.c = c[COORD_W-1:0];
    return r;
  endfunction

endpackage

// ----- rtl/core/cell_grid_neighbor_counter_top.sv -----
// Grid cell store with neighbor counting.
// Input channel s_axis: tuser carries the opcode (write, read, Moore count,
// von Neumann count), tdata the column, row and cell state. Output channel
// m_axis gives one result per item: cell value, neighbor count, write flag.
// Grid size and wrap mode are set through the cfg write port; the user
// writes them only while idle, the block does not enforce it. Items enter
// a two-entry queue, so the sender is taken while a result still waits on
// the output register. Items are handled by the single-port grid memory
// (one read per cycle) and a three-stage address/read/compare pipeline
// behind it; reads and counts in toroidal mode first run a bit-serial
// coordinate reduction. The back end takes the next item from the queue
// only once the last result has gone to the output register.
// After reset the grid memory is cleared one cell per cycle, all 4096
// cells; s_axis_tready stays low meanwhile, cfg writes are taken.
// A stalled m_axis holds its result; the back end then waits and the
// queue fills, after which s_axis_tready drops.
module cell_grid_neighbor_counter_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // x_coord, y_coord, key_state, zero pad
  input  logic [cgnc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // opcode
  input  logic [cgnc_pkg::OP_W-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // cell_value, neighbor_count, write_done, zero pad
  output logic [cgnc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [cgnc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cgnc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import cgnc_pkg::*;

  logic [SIZE_W-1:0] width_q, width_d, height_q, height_d;
  logic              wrap_q, wrap_d;
  cfg_t              cfg;
  logic              q_valid, q_pop, clearing;
  item_t             q_item;
  result_t           res;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    wrap_d   = wrap_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_WIDTH:  width_d  = cfg_data_i;
        CFG_IDX_HEIGHT: height_d = cfg_data_i;
        CFG_IDX_WRAP:   wrap_d   = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= COLS_MAX_S;
      height_q <= ROWS_MAX_S;
      wrap_q   <= 1'b0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      wrap_q   <= wrap_d;
    end
  end

  assign cfg.w    = eff_size(width_q, COLS_MAX_S);
  assign cfg.h    = eff_size(height_q, ROWS_MAX_S);
  assign cfg.wrap = wrap_q;

  cgnc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .hold_i        (clearing),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  cgnc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .clearing_o  (clearing),
    .res_valid_o (m_axis_tvalid),
    .res_o       (res),
    .res_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {(OUT_DATA_W - OUT_FIELDS_W)'(0), res};

endmodule

// ----- rtl/core/cgnc_ram.sv -----
module cgnc_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/cgnc_front.sv -----
module cgnc_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [cgnc_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic [cgnc_pkg::OP_W-1:0]      s_axis_tuser,
  input  logic                           hold_i,
  output logic                           q_valid_o,
  output cgnc_pkg::item_t                q_item_o,
  input  logic                           q_pop_i
);
  import cgnc_pkg::*;

  item_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  item_t              in_item;
  logic               push;

  always_comb begin
    case (s_axis_tuser)
      OP_WRITE: in_item.kind = KIND_WRITE;
      OP_READ:  in_item.kind = KIND_READ;
      OP_MOORE: in_item.kind = KIND_MOORE;
      OP_VN:    in_item.kind = KIND_VN;
      default:  in_item.kind = KIND_WRITE;
    endcase
    in_item.x_coord   = s_axis_tdata[X_LSB +: COORD_W];
    in_item.y_coord   = s_axis_tdata[Y_LSB +: COORD_W];
    in_item.key_state = s_axis_tdata[ST_LSB +: STATE_W];
  end

  assign s_axis_tready = (cnt_q != QCNT_W'(QUEUE_DEPTH)) && !hold_i;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid_o     = (cnt_q != '0);
  assign q_item_o      = slot_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + QPTR_W'(1) : wr_q;
    rd_d  = q_pop_i ? rd_q + QPTR_W'(1) : rd_q;
    cnt_d = cnt_q + QCNT_W'(push) - QCNT_W'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= in_item;
    end
  end

endmodule

// ----- rtl/core/cgnc_back.sv -----
module cgnc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cgnc_pkg::cfg_t    cfg_i,
  input  logic              q_valid_i,
  input  cgnc_pkg::item_t   q_item_i,
  output logic              q_pop_o,
  output logic              clearing_o,
  output logic              res_valid_o,
  output cgnc_pkg::result_t res_o,
  input  logic              res_ready_i
);
  import cgnc_pkg::*;

  typedef struct packed {
    logic               valid;
    logic               last;
    kind_e              kind;
    logic               off;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
  } s1_t;

  typedef struct packed {
    logic  valid;
    logic  last;
    kind_e kind;
    logic  off;
    logic  done;
  } s2_t;

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  item_t               item_q, item_d;
  logic [NB_W-1:0]     nb_q, nb_d, last_nb;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [COORD_W-1:0]  xs_q, xs_d, ys_q, ys_d;
  logic [COORD_W-1:0]  rx_q, rx_d, ry_q, ry_d;
  logic [SIZE_W-1:0]   tx, ty;
  logic [COUNT_W-1:0]  cnt_q, cnt_d, cnt_sum;
  logic [AREA_W-1:0]   area_q, area_d, prod;
  s1_t                 s1_q, s1_d;
  s2_t                 s2_q, s2_d;
  result_t             fin_q, fin_d, out_q, out_d;
  logic                out_valid_q, out_valid_d;
  coord_t              ncx, ncy;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [STATE_W-1:0]  ram_wdata, ram_rdata, rd_val;
  logic [CELL_BITS-1:0] ram_cell;
  logic                match, counting;

  cgnc_ram #(
    .Width (CELL_BITS),
    .Depth (STORE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata[CELL_BITS-1:0]),
    .rdata_o (ram_cell)
  );

  always_comb begin
    case (item_q.kind)
      KIND_MOORE: last_nb = NB_MOORE_LAST;
      KIND_VN:    last_nb = NB_VN_LAST;
      default:    last_nb = '0;
    endcase
  end

  always_comb begin
    if (item_q.kind == KIND_READ) begin
      ncx = next_coord(item_q.x_coord, rx_q, cfg_i.w, cfg_i.wrap, OFF_Z);
      ncy = next_coord(item_q.y_coord, ry_q, cfg_i.h, cfg_i.wrap, OFF_Z);
    end else begin
      ncx = next_coord(item_q.x_coord, rx_q, cfg_i.w, cfg_i.wrap, nb_dx(nb_q));
      ncy = next_coord(item_q.y_coord, ry_q, cfg_i.h, cfg_i.wrap, nb_dy(nb_q));
    end
  end

  // restoring remainder, one bit per cycle
  assign tx = {rx_q, xs_q[COORD_W-1]};
  assign ty = {ry_q, ys_q[COORD_W-1]};

  // stage 2: linear address and write check
  assign area_d = AREA_W'(cfg_i.w * cfg_i.h);
  assign prod   = AREA_W'(s1_q.cy) * AREA_W'(cfg_i.w) + AREA_W'(s1_q.cx);

  always_comb begin
    s2_d.valid = s1_q.valid;
    s2_d.last  = s1_q.last;
    s2_d.kind  = s1_q.kind;
    s2_d.off   = s1_q.off;
    s2_d.done  = s1_q.valid && (s1_q.kind == KIND_WRITE) && (prod < area_q);
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_addr  = clr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = s2_d.done;
      ram_addr  = prod[ADDR_W-1:0];
      ram_wdata = item_q.key_state;
    end
  end

  // stage 3: compare and accumulate
  assign ram_rdata = STATE_W'(ram_cell);
  assign rd_val   = s2_q.off ? '0 : ram_rdata;
  assign match    = (rd_val == item_q.key_state);
  assign counting = (s2_q.kind == KIND_MOORE) || (s2_q.kind == KIND_VN);
  assign cnt_sum  = cnt_q + COUNT_W'(match && counting);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    item_d      = item_q;
    nb_d        = nb_q;
    step_d      = step_q;
    xs_d        = xs_q;
    ys_d        = ys_q;
    rx_d        = rx_q;
    ry_d        = ry_q;
    cnt_d       = cnt_q;
    fin_d       = fin_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_ready_i;
    q_pop_o     = 1'b0;

    s1_d.valid  = 1'b0;
    s1_d.last   = (nb_q == last_nb);
    s1_d.kind   = item_q.kind;
    if (item_q.kind == KIND_WRITE) begin
      s1_d.off = 1'b0;
      s1_d.cx  = item_q.x_coord;
      s1_d.cy  = item_q.y_coord;
    end else begin
      s1_d.off = ncx.off || ncy.off;
      s1_d.cx  = ncx.c;
      s1_d.cy  = ncy.c;
    end

    if (s2_q.valid) begin
      cnt_d = cnt_sum;
      if (s2_q.last) begin
        fin_d.cell_value     = (s2_q.kind == KIND_READ) ? rd_val : '0;
        fin_d.neighbor_count = counting ? cnt_sum : '0;
        fin_d.write_done     = s2_q.done;
      end
    end

    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(STORE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          nb_d    = '0;
          cnt_d   = '0;
          step_d  = '0;
          xs_d    = q_item_i.x_coord;
          ys_d    = q_item_i.y_coord;
          rx_d    = '0;
          ry_d    = '0;
          if (cfg_i.wrap && (q_item_i.kind != KIND_WRITE)) begin
            state_d = ST_MOD;
          end else begin
            state_d = ST_ISSUE;
          end
        end
      end
      ST_MOD: begin
        rx_d   = (tx >= cfg_i.w) ? COORD_W'(tx - cfg_i.w) : tx[COORD_W-1:0];
        ry_d   = (ty >= cfg_i.h) ? COORD_W'(ty - cfg_i.h) : ty[COORD_W-1:0];
        xs_d   = xs_q << 1;
        ys_d   = ys_q << 1;
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(COORD_W - 1)) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        s1_d.valid = 1'b1;
        if (nb_q == last_nb) begin
          state_d = ST_DRAIN;
        end else begin
          nb_d = nb_q + NB_W'(1);
        end
      end
      ST_DRAIN: begin
        if (s2_q.valid && s2_q.last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || res_ready_i) begin
          out_d       = fin_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      s1_q        <= '0;
      s2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      s1_q        <= s1_d;
      s2_q        <= s2_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    nb_q      <= nb_d;
    step_q    <= step_d;
    xs_q      <= xs_d;
    ys_q      <= ys_d;
    rx_q      <= rx_d;
    ry_q      <= ry_d;
    cnt_q     <= cnt_d;
    area_q    <= area_d;
    fin_q     <= fin_d;
    out_q     <= out_d;
  end

  assign clearing_o  = (state_q == ST_CLEAR);
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

// ----- rtl/core/cgnc_checker.sv -----
`include "cell_grid_neighbor_counter_top_assert.svh"

module cgnc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [cgnc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import cgnc_pkg::*;

  logic [STATE_W-1:0] value;
  logic [COUNT_W-1:0] count;
  logic               done;

  assign value = m_axis_tdata[VALUE_LSB +: STATE_W];
  assign count = m_axis_tdata[COUNT_LSB +: COUNT_W];
  assign done  = m_axis_tdata[DONE_BIT];

  `CGNC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `CGNC_ASSERT_NOW(a_write_alone, clk_i, rst_ni, m_axis_tvalid && done, (value == '0) && (count == '0), "write result carries read or count data")
  `CGNC_ASSERT_NOW(a_count_max, clk_i, rst_ni, m_axis_tvalid, count <= COUNT_MAX, "neighbor count above eight")
  `CGNC_ASSERT_NOW(a_read_alone, clk_i, rst_ni, m_axis_tvalid && (value != '0), (count == '0) && !done, "read result carries count or write flag")

endmodule

bind cell_grid_neighbor_counter_top cgnc_checker u_cgnc_checker (.*);
